FILE: hw/rtl/adler32_checksum_defines.svh
// Assertion macros shared by the Adler-32 checksum RTL.
`ifndef ADLER32_CHECKSUM_DEFINES_SVH
`define ADLER32_CHECKSUM_DEFINES_SVH

// Same-cycle implication, disabled while reset is held.
`define ADLER_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define ADLER_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hw/rtl/adler_pkg.sv
// Package with the constants and types shared by the Adler-32 checksum modules.
package adler_pkg;

    // Adler-32 modulus and the residue of 2^16 under it.
    localparam logic [15:0] ADLER_MOD   = 16'd65521;
    localparam logic [3:0]  FOLD_FACTOR = 4'd15;

    // Field and lane geometry.
    localparam int LANE_COUNT     = 4;
    localparam int BYTE_W         = 8;
    localparam int COUNT_W        = 3;
    localparam int SUM_W          = 16;
    localparam int CHECKSUM_W     = 32;
    localparam int IN_TDATA_W     = 40;
    localparam int WEIGHTED_W     = 11;
    localparam int BYTE_SUM_W     = 10;
    localparam int WEIGHTED_SUM_W = 12;

    localparam logic [COUNT_W-1:0] MAX_COUNT = 3'd4;

    // Reset values of the running sums.
    localparam logic [SUM_W-1:0] LOW_INIT  = 16'd1;
    localparam logic [SUM_W-1:0] HIGH_INIT = 16'd0;

    // Lane results of one item, registered ahead of the merge.
    typedef struct packed {
        logic [BYTE_SUM_W-1:0]     byte_sum;
        logic [WEIGHTED_SUM_W-1:0] weighted_sum;
        logic [COUNT_W-1:0]        count;
        logic                      last;
    } adler_lanes_t;

endpackage

FILE: hw/rtl/adler_lane.sv
// One byte lane: masks its byte and weights it by the number of sum updates it feeds.
module adler_lane (
    input  logic [adler_pkg::BYTE_W-1:0]     byte_in,
    input  logic [adler_pkg::COUNT_W-1:0]    weight,
    output logic [adler_pkg::BYTE_W-1:0]     byte_used,
    output logic [adler_pkg::WEIGHTED_W-1:0] weighted
);

    // A zero weight means the byte lies beyond the valid count.
    always_comb begin
        byte_used = (weight != '0) ? byte_in : '0;
        weighted  = adler_pkg::WEIGHTED_W'(byte_in) * adler_pkg::WEIGHTED_W'(weight);
    end

endmodule

FILE: hw/rtl/adler_merge.sv
// Merge stage: folds the combined lane results into the running sums and reduces them.
module adler_merge (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              advance,
    input  adler_pkg::adler_lanes_t           lanes,
    output logic [adler_pkg::CHECKSUM_W-1:0]  checksum_next
);

    logic [adler_pkg::SUM_W-1:0] low_sum_reg;
    logic [adler_pkg::SUM_W-1:0] high_sum_reg;
    logic [adler_pkg::SUM_W-1:0] low_sum_next;
    logic [adler_pkg::SUM_W-1:0] high_sum_next;

    logic [16:0] low_tmp;
    logic [18:0] scaled_low;
    logic [18:0] high_tmp;
    logic [16:0] high_fold;
    logic [16:0] high_red;

    // Low sum: the byte total stays below the modulus, so one subtract suffices.
    always_comb begin
        low_tmp = 17'(low_sum_reg) + 17'(lanes.byte_sum);
        if (low_tmp >= 17'(adler_pkg::ADLER_MOD)) begin
            low_sum_next = 16'(low_tmp - 17'(adler_pkg::ADLER_MOD));
        end else begin
            low_sum_next = low_tmp[15:0];
        end
    end

    // High sum: every byte update adds the old low sum once, plus its weighted bytes.
    // The upper bits are folded back with 2^16 = 15 under the modulus, then one subtract.
    always_comb begin
        scaled_low = 19'(low_sum_reg) * 19'(lanes.count);
        high_tmp   = 19'(high_sum_reg) + scaled_low + 19'(lanes.weighted_sum);
        high_fold  = 17'(high_tmp[15:0])
                   + 17'(high_tmp[18:16]) * 17'(adler_pkg::FOLD_FACTOR);
        if (high_fold >= 17'(adler_pkg::ADLER_MOD)) begin
            high_red = high_fold - 17'(adler_pkg::ADLER_MOD);
        end else begin
            high_red = high_fold;
        end
        high_sum_next = high_red[15:0];
        checksum_next = {high_sum_next, low_sum_next};
    end

    // Running sums; the last transaction of a message restarts them.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            low_sum_reg  <= adler_pkg::LOW_INIT;
            high_sum_reg <= adler_pkg::HIGH_INIT;
        end else if (advance) begin
            if (lanes.last) begin
                low_sum_reg  <= adler_pkg::LOW_INIT;
                high_sum_reg <= adler_pkg::HIGH_INIT;
            end else begin
                low_sum_reg  <= low_sum_next;
                high_sum_reg <= high_sum_next;
            end
        end
    end

endmodule

FILE: hw/rtl/adler32_checksum.sv
// Top level of the streaming Adler-32 checksum engine.
//
//   channel | direction | tdata fields (lowest bit first)                  | tlast
//   s_axis  | in        | byte_zero, byte_one, byte_two, byte_three,       | end_of_message
//           |           | valid_count, zero padding to 40 bits             |
//   m_axis  | out       | checksum                                         | none
//
// One transaction is taken per cycle while the lane register is not stalled; the last
// input passes the lane register, then its checksum is held in the output register. The
// rate is set by the running-sum loop in the merge stage, updated from the lane register.
// Reset (aresetn low, synchronous) empties both stages and sets the sums to one and zero.
// An unaccepted checksum only stalls input once a further last transaction reaches the
// lane register; other transactions keep flowing into the sums.
`include "adler32_checksum_defines.svh"

module adler32_checksum (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // byte_zero [7:0], byte_one [15:8], byte_two [23:16], byte_three [31:24],
    // valid_count [34:32], padding [39:35]
    input  logic [adler_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
    input  logic                               s_axis_tlast,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // checksum [31:0]
    output logic [adler_pkg::CHECKSUM_W-1:0]   m_axis_tdata
);

    localparam int LW = adler_pkg::LANE_COUNT;

    logic [adler_pkg::COUNT_W-1:0]    count_sat;
    logic [adler_pkg::BYTE_W-1:0]     lane_byte  [LW];
    logic [adler_pkg::COUNT_W-1:0]    lane_weight[LW];
    logic [adler_pkg::BYTE_W-1:0]     lane_used  [LW];
    logic [adler_pkg::WEIGHTED_W-1:0] lane_wtd   [LW];

    adler_pkg::adler_lanes_t lanes_comb;
    adler_pkg::adler_lanes_t s1_reg;
    logic                    s1_valid_reg;
    logic                    s1_valid_next;
    logic                    s1_move;
    logic                    in_accept;

    logic                               m_valid_reg;
    logic                               m_valid_next;
    logic [adler_pkg::CHECKSUM_W-1:0]   m_data_reg;
    logic [adler_pkg::CHECKSUM_W-1:0]   checksum_next;

    // Counts above four use all four bytes.
    always_comb begin
        if (s_axis_tdata[34:32] > adler_pkg::MAX_COUNT) begin
            count_sat = adler_pkg::MAX_COUNT;
        end else begin
            count_sat = s_axis_tdata[34:32];
        end
    end

    // Byte lanes; lane k feeds the high sum once for its own and each later byte update.
    for (genvar k = 0; k < LW; k++) begin : g_lane
        assign lane_byte[k]   = s_axis_tdata[k*adler_pkg::BYTE_W +: adler_pkg::BYTE_W];
        assign lane_weight[k] = (count_sat > adler_pkg::COUNT_W'(k))
                              ? count_sat - adler_pkg::COUNT_W'(k) : '0;

        adler_lane u_lane (
            .byte_in   (lane_byte[k]),
            .weight    (lane_weight[k]),
            .byte_used (lane_used[k]),
            .weighted  (lane_wtd[k])
        );
    end

    // Combine the lanes into one transaction summary.
    always_comb begin
        lanes_comb.byte_sum     = '0;
        lanes_comb.weighted_sum = '0;
        for (int i = 0; i < LW; i++) begin
            lanes_comb.byte_sum     = lanes_comb.byte_sum
                                    + adler_pkg::BYTE_SUM_W'(lane_used[i]);
            lanes_comb.weighted_sum = lanes_comb.weighted_sum
                                    + adler_pkg::WEIGHTED_SUM_W'(lane_wtd[i]);
        end
        lanes_comb.count = count_sat;
        lanes_comb.last  = s_axis_tlast;
    end

    // Handshake: the lane register drains unless a checksum has nowhere to go.
    always_comb begin
        s1_move       = s1_valid_reg && (!s1_reg.last || !m_valid_reg || m_axis_tready);
        s_axis_tready = !s1_valid_reg || s1_move;
        in_accept     = s_axis_tvalid && s_axis_tready;

        if (in_accept) begin
            s1_valid_next = 1'b1;
        end else if (s1_move) begin
            s1_valid_next = 1'b0;
        end else begin
            s1_valid_next = s1_valid_reg;
        end

        if (s1_move && s1_reg.last) begin
            m_valid_next = 1'b1;
        end else if (m_axis_tready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    // Control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            s1_valid_reg <= s1_valid_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        if (in_accept) begin
            s1_reg <= lanes_comb;
        end
        if (s1_move && s1_reg.last) begin
            m_data_reg <= checksum_next;
        end
    end

    // Running sums and their reduction.
    adler_merge u_merge (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .advance       (s1_move),
        .lanes         (s1_reg),
        .checksum_next (checksum_next)
    );

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;

    // Checks on the pipeline control and the reduced sums.
    `ADLER_ASSERT_NEXT(a_accept_fills, aclk, aresetn, in_accept, s1_valid_reg, "accepted transaction lost before the lane register")
    `ADLER_ASSERT_NOW(a_stall_cause, aclk, aresetn, s1_valid_reg && !s1_move, s1_reg.last && m_valid_reg && !m_axis_tready, "lane register stalled without a waiting checksum")
    `ADLER_ASSERT_NEXT(a_result_shown, aclk, aresetn, s1_move && s1_reg.last, m_valid_reg, "checksum not presented after the last transaction")
    `ADLER_ASSERT_NOW(a_sums_reduced, aclk, aresetn, s1_move, (checksum_next[15:0] < adler_pkg::ADLER_MOD) && (checksum_next[31:16] < adler_pkg::ADLER_MOD), "running sum not reduced below the modulus")

endmodule

FILE: test/adler32_checksum_tb.sv
// Self-checking testbench for the streaming Adler-32 checksum engine.
`timescale 1ns / 1ps

module adler32_checksum_tb;

    localparam int COUNT_LSB   = adler_pkg::LANE_COUNT * adler_pkg::BYTE_W;
    localparam int CYCLE_LIMIT = 200000;

    // Clock, reset and the two stream channels.
    logic                                aclk;
    logic                                aresetn       = 1'b0;
    logic                                s_axis_tvalid = 1'b0;
    logic                                s_axis_tready;
    logic [adler_pkg::IN_TDATA_W-1:0]    s_axis_tdata  = '0;
    logic                                s_axis_tlast  = 1'b0;
    logic                                m_axis_tvalid;
    logic                                m_axis_tready = 1'b0;
    logic [adler_pkg::CHECKSUM_W-1:0]    m_axis_tdata;

    // Running sums of the message in flight, as the block should hold them.
    logic [adler_pkg::SUM_W-1:0]         run_low  = adler_pkg::LOW_INIT;
    logic [adler_pkg::SUM_W-1:0]         run_high = adler_pkg::HIGH_INIT;
    logic [adler_pkg::CHECKSUM_W-1:0]    pending_checksums [$];
    logic [adler_pkg::CHECKSUM_W-1:0]    oldest_checksum;

    int                     gap_pct     = 0;
    int                     stall_pct   = 0;
    int                     error_count = 0;
    int                     cycle_count = 0;

    adler32_checksum uut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // Watchdog on the whole run.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("%0t: timeout with %0d checksums outstanding", $time,
                     pending_checksums.size());
            $display("adler32_checksum_tb: FAIL");
            $finish;
        end
    end

    // The receiver stalls at random according to the current phase.
    always @(negedge aclk) begin
        m_axis_tready <= ($urandom_range(99) >= stall_pct);
    end

    // Each accepted checksum is compared with the oldest one predicted.
    always @(posedge aclk) begin
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            if (pending_checksums.size() == 0) begin
                $display("%0t: unexpected checksum, expected none, actual %h",
                         $time, m_axis_tdata);
                error_count++;
            end else begin
                oldest_checksum = pending_checksums.pop_front();
                if (m_axis_tdata !== oldest_checksum) begin
                    $display("%0t: checksum mismatch, expected %h, actual %h",
                             $time, oldest_checksum, m_axis_tdata);
                    error_count++;
                end
            end
        end
    end

    // Folds one accepted transaction into the running sums; on the last one of a
    // message the checksum is queued and the sums start again.
    function automatic void adler_fold(input logic [adler_pkg::IN_TDATA_W-1:0] word,
                                       input logic last);
        int unsigned low;
        int unsigned high;
        int unsigned count;
        low   = 32'(run_low);
        high  = 32'(run_high);
        count = 32'(word[COUNT_LSB +: adler_pkg::COUNT_W]);
        if (count > adler_pkg::LANE_COUNT)
            count = adler_pkg::LANE_COUNT;
        for (int k = 0; k < count; k++) begin
            low  += 32'(word[adler_pkg::BYTE_W*k +: adler_pkg::BYTE_W]);
            high += low;
        end
        low  = low % 32'(adler_pkg::ADLER_MOD);
        high = high % 32'(adler_pkg::ADLER_MOD);
        if (last) begin
            pending_checksums.push_back({high[adler_pkg::SUM_W-1:0],
                                         low[adler_pkg::SUM_W-1:0]});
            low  = 32'(adler_pkg::LOW_INIT);
            high = 32'(adler_pkg::HIGH_INIT);
        end
        run_low  = low[adler_pkg::SUM_W-1:0];
        run_high = high[adler_pkg::SUM_W-1:0];
    endfunction

    // Offers one transaction, after a random gap, and waits for it to be taken.
    // Called and left at a falling edge.
    task automatic send_word(input logic [31:0] lanes,
                             input logic [adler_pkg::COUNT_W-1:0] count,
                             input logic last);
        logic [adler_pkg::IN_TDATA_W-1:0] word;
        word = '0;
        word[31:0] = lanes;
        word[COUNT_LSB +: adler_pkg::COUNT_W] = count;
        while ($urandom_range(99) < gap_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= word;
        s_axis_tlast  <= last;
        do @(posedge aclk); while (!s_axis_tready);
        adler_fold(word, last);
        @(negedge aclk);
    endtask

    function automatic logic [adler_pkg::BYTE_W-1:0] pick_byte(input int ff_pct);
        int r;
        r = $urandom_range(99);
        if (r < ff_pct)
            return 8'hFF;
        else if (r < ff_pct + 10)
            return 8'h00;
        return 8'($urandom_range(255));
    endfunction

    function automatic logic [adler_pkg::COUNT_W-1:0] pick_count();
        if ($urandom_range(9) < 5)
            return adler_pkg::MAX_COUNT;
        return 3'($urandom_range(7));
    endfunction

    // Empty messages straight after reset and after an empty transaction.
    task automatic test_empty_message();
        send_word(32'h0000_0000, 3'd0, 1'b1);
        send_word(32'hFFFF_FFFF, 3'd0, 1'b0);
        send_word(32'h5A5A_5A5A, 3'd0, 1'b1);
    endtask

    // All-zero and all-ones bytes over whole and single-byte messages.
    task automatic test_byte_extremes();
        send_word(32'h0000_0000, 3'd4, 1'b1);
        send_word(32'hFFFF_FFFF, 3'd4, 1'b0);
        send_word(32'hFFFF_FFFF, 3'd4, 1'b0);
        send_word(32'hFFFF_FFFF, 3'd4, 1'b0);
        send_word(32'hFFFF_FFFF, 3'd4, 1'b1);
        send_word(32'h0000_00FF, 3'd1, 1'b1);
    endtask

    // Counts of five to seven must behave as four.
    task automatic test_count_saturation();
        send_word(32'h0102_0304, 3'd5, 1'b1);
        send_word(32'hF0E1_D2C3, 3'd6, 1'b1);
        send_word(32'h8080_8080, 3'd7, 1'b0);
        send_word(32'h1234_5678, 3'd0, 1'b1);
    endtask

    // Bytes beyond the count carry noise that must be ignored.
    task automatic test_unused_lanes();
        send_word(32'hFFFF_FF80, 3'd1, 1'b0);
        send_word(32'hFFFF_7F01, 3'd2, 1'b0);
        send_word(32'hFF01_0203, 3'd3, 1'b0);
        send_word(32'hFFFF_FFFF, 3'd0, 1'b0);
        send_word(32'hA5A5_A5A5, 3'd4, 1'b1);
    endtask

    // Whole messages with random content under one idling pattern. Now and then a
    // long message heavy in 0xFF bytes drives both sums through the modulus.
    task automatic test_random_traffic(input int gap, input int stall, input int items);
        int sent;
        int length;
        int ff_pct;
        logic [31:0] lanes;
        gap_pct   = gap;
        stall_pct = stall;
        sent      = 0;
        while (sent < items) begin
            if ($urandom_range(9) == 0) begin
                length = $urandom_range(80, 30);
                ff_pct = 80;
            end else begin
                length = $urandom_range(8, 1);
                ff_pct = 10;
            end
            for (int i = 0; i < length; i++) begin
                lanes = {pick_byte(ff_pct), pick_byte(ff_pct),
                         pick_byte(ff_pct), pick_byte(ff_pct)};
                send_word(lanes, pick_count(), i == length - 1);
                sent++;
            end
        end
    endtask

    // Test sequence.
    initial begin
        repeat (9) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        test_empty_message();
        test_byte_extremes();
        test_count_saturation();
        test_unused_lanes();
        test_random_traffic(0, 0, 125);
        test_random_traffic(45, 0, 125);
        test_random_traffic(0, 45, 125);
        test_random_traffic(25, 25, 125);

        // Drain the outstanding checksums, then allow for the pipeline depth.
        s_axis_tvalid <= 1'b0;
        while (pending_checksums.size() != 0)
            @(posedge aclk);
        repeat (8) @(posedge aclk);

        if (error_count == 0)
            $display("adler32_checksum_tb: PASS");
        else
            $display("adler32_checksum_tb: FAIL");
        $finish;
    end

endmodule
